// ----- hdl/scme_pkg.sv -----
// shared types and constants for the sparse column matrix engine
package scme_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned CfgW  = 7;
  localparam int unsigned CntW  = 10;

  // matrix sizes are tied to the 6-bit row and column fields
  localparam int unsigned MaxRows = 64;
  localparam int unsigned MaxCols = 64;

  typedef enum logic [2:0] {
    OP_SET   = 3'd0,
    OP_ADD   = 3'd1,
    OP_READ  = 3'd2,
    OP_MUL   = 3'd3,
    OP_RDCLR = 3'd4,
    OP_SCALE = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic signed [DataW-1:0] SatMax = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] SatMin = 32'sh80000000;

  // saturate a 34-bit signed sum to 32 bits
  function automatic logic signed [DataW-1:0] sat34(input logic signed [33:0] x);
    logic signed [DataW-1:0] r;
    if (x > 34'sh07fffffff) r = SatMax;
    else if (x < -34'sh080000000) r = SatMin;
    else r = x[DataW-1:0];
    return r;
  endfunction

  // floor of a 64-bit product shifted by 16, saturated to 32 bits
  function automatic logic signed [DataW-1:0] satq(input logic signed [63:0] p);
    logic signed [47:0] s;
    logic signed [DataW-1:0] r;
    s = p[63:16];
    if (s > 48'sh00007fffffff) r = SatMax;
    else if (s < -48'sh000080000000) r = SatMin;
    else r = s[DataW-1:0];
    return r;
  endfunction

  // accumulator plus the full floored product, saturated once at the end
  function automatic logic signed [DataW-1:0] sat_acc(input logic signed [DataW-1:0] acc,
                                                       input logic signed [63:0] p);
    logic signed [48:0] s;
    logic signed [DataW-1:0] r;
    s = 49'(acc) + 49'($signed(p[63:16]));
    if (s > 49'sh00007fffffff) r = SatMax;
    else if (s < -49'sh000080000000) r = SatMin;
    else r = s[DataW-1:0];
    return r;
  endfunction

endpackage

// ----- hdl/scme_mul.sv -----
// registered 32x32 signed multiplier built from four 16x16 partial products
module scme_mul (
  input  logic                     clk,
  input  logic signed [31:0]       a,
  input  logic signed [31:0]       b,
  output logic signed [63:0]       p
);
  logic signed [16:0] ah, bh;
  logic        [15:0] al, bl;
  logic signed [33:0] pll, plh, phl;
  logic signed [33:0] phh;
  logic signed [63:0] sum;

  always_comb begin
    ah = {a[31], a[31:16]};
    bh = {b[31], b[31:16]};
    al = a[15:0];
    bl = b[15:0];
    sum = 64'(pll) + (64'(plh) <<< 16) + (64'(phl) <<< 16) + (64'(phh) <<< 32);
  end

  // partial products registered, then summed
  always_ff @(posedge clk) begin
    pll <= $signed({2'b00, 32'(al * bl)});
    plh <= $signed({1'b0, al}) * bh;
    phl <= ah * $signed({1'b0, bl});
    phh <= 34'(ah * bh);
    p   <= sum;
  end
endmodule

// ----- hdl/sparse_column_matrix_engine_unit.sv -----
// top level: sparse column matrix engine with slot, fill and result memories
//
// channel | direction | handshake                 | payload
// in      | in        | in_valid / in_ready       | op, row, col, value
// out     | out       | out_valid / out_ready     | data, status, nonzeros
// cfg     | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// ops 0-2 search the slots of the column in turn; op 3 walks every stored slot of the column
// through the multiplier; op 4, range errors and unused ops answer without a search.
// op 5 sweeps all 64 columns, scaling every stored slot.
// after reset a clearing pass zeroes fills and results, input not ready.
// one item at a time; input is ready again the cycle after the result is taken.
module sparse_column_matrix_engine_unit #(
  parameter int unsigned SLOTS_PER_COL = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [5:0]  row,
  input  logic [5:0]  col,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] data,
  output logic [1:0]  status,
  output logic [9:0]  nonzeros,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  localparam int unsigned RW  = $clog2(scme_pkg::MaxRows);
  localparam int unsigned CW  = $clog2(scme_pkg::MaxCols);
  localparam int unsigned KW  = (SLOTS_PER_COL > 1) ? $clog2(SLOTS_PER_COL) : 1;
  localparam int unsigned FW  = $clog2(SLOTS_PER_COL + 1);
  localparam int unsigned SW  = CW + KW;
  localparam int unsigned SD  = 1 << SW;
  localparam int unsigned CLRN = (scme_pkg::MaxRows > scme_pkg::MaxCols) ?
                                 scme_pkg::MaxRows : scme_pkg::MaxCols;
  localparam int unsigned CLW = $clog2(CLRN + 1);

  typedef enum logic [11:0] {
    S_CLR   = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_FILL  = 12'b000000000100,
    S_FILLW = 12'b000000001000,
    S_SRCH  = 12'b000000010000,
    S_SRCHW = 12'b000000100000,
    S_DEC   = 12'b000001000000,
    S_MUL   = 12'b000010000000,
    S_MULW  = 12'b000100000000,
    S_ACC   = 12'b001000000000,
    S_RES   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state;

  // memories
  logic [5:0]              slot_row_mem [SD];
  logic signed [31:0]      slot_val_mem [SD];
  logic [FW-1:0]           fill_mem     [scme_pkg::MaxCols];
  logic signed [31:0]      acc_mem      [scme_pkg::MaxRows];

  logic [6:0] rows_in_use, cols_in_use;
  logic [2:0] op_q;
  logic [5:0] row_q, col_q;
  logic signed [31:0] val_q;
  logic [FW-1:0] fill_q;
  logic [KW:0] k;
  logic [CW:0] ci;
  logic [CLW-1:0] clr;
  logic found;
  logic [KW-1:0] found_k;
  logic [5:0] rd_row;
  logic signed [31:0] rd_val;
  logic signed [31:0] acc_rd;
  logic [5:0] acc_row;
  logic [9:0] count;
  logic signed [63:0] prod;
  logic [2:0] wait_cnt;

  logic [6:0] nr, nc;
  logic row_ok, col_ok;
  logic [SW-1:0] slot_addr;

  assign nr = (rows_in_use > 7'(scme_pkg::MaxRows)) ? 7'(scme_pkg::MaxRows) : rows_in_use;
  assign nc = (cols_in_use > 7'(scme_pkg::MaxCols)) ? 7'(scme_pkg::MaxCols) : cols_in_use;
  assign row_ok = {1'b0, row_q} < nr;
  assign col_ok = {1'b0, col_q} < nc;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign nonzeros  = count;

  scme_mul u_mul (.clk(clk), .a(rd_val), .b(val_q), .p(prod));

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 7'd64;
      cols_in_use <= 7'd64;
    end else if (cfg_valid) begin
      if (cfg_index == scme_pkg::REG_ROWS) rows_in_use <= cfg_data;
      else cols_in_use <= cfg_data;
    end
  end

  always_comb begin
    slot_addr = {col_q[CW-1:0], k[KW-1:0]};
    if (state == S_IDLE || state == S_FILL) slot_addr = '0;
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          if (clr < CLW'(scme_pkg::MaxCols)) fill_mem[clr[CW-1:0]] <= '0;
          if (clr < CLW'(scme_pkg::MaxRows)) acc_mem[clr[RW-1:0]] <= '0;
          clr <= clr + 1'b1;
          if (clr == CLW'(CLRN - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q <= op; row_q <= row; col_q <= col; val_q <= value;
            k <= '0; ci <= '0; found <= 1'b0; found_k <= '0;
            data <= '0;
            status <= scme_pkg::ST_OK;
            state <= S_FILL;
          end
        end
        S_FILL: begin
          // range checks and column fill read
          priority if (op_q == scme_pkg::OP_SET || op_q == scme_pkg::OP_ADD ||
                       op_q == scme_pkg::OP_READ) begin
            if (!row_ok || !col_ok) begin
              status <= scme_pkg::ST_RANGE; state <= S_OUT; out_valid <= 1'b1;
            end else begin
              fill_q <= fill_mem[col_q[CW-1:0]]; state <= S_SRCH;
            end
          end else if (op_q == scme_pkg::OP_MUL) begin
            if (!col_ok) begin
              status <= scme_pkg::ST_RANGE; state <= S_OUT; out_valid <= 1'b1;
            end else begin
              fill_q <= fill_mem[col_q[CW-1:0]]; state <= S_MUL;
            end
          end else if (op_q == scme_pkg::OP_RDCLR) begin
            if (!row_ok) begin
              status <= scme_pkg::ST_RANGE; state <= S_OUT; out_valid <= 1'b1;
            end else begin
              data <= acc_mem[row_q[RW-1:0]];
              acc_mem[row_q[RW-1:0]] <= '0;
              state <= S_OUT; out_valid <= 1'b1;
            end
          end else if (op_q == scme_pkg::OP_SCALE) begin
            col_q <= '0;
            fill_q <= fill_mem[0];
            state <= S_MUL;
          end else begin
            state <= S_OUT; out_valid <= 1'b1;
          end
        end
        S_SRCH: begin
          if (k >= (KW+1)'(fill_q)) state <= S_DEC;
          else begin
            rd_row <= slot_row_mem[slot_addr];
            rd_val <= slot_val_mem[slot_addr];
            state <= S_SRCHW;
          end
        end
        S_SRCHW: begin
          if (rd_row == row_q) begin
            found <= 1'b1; found_k <= k[KW-1:0]; state <= S_DEC;
          end else begin
            k <= k + 1'b1; state <= S_SRCH;
          end
        end
        S_DEC: begin
          out_valid <= 1'b1;
          state <= S_OUT;
          if (op_q == scme_pkg::OP_READ) begin
            if (found) data <= rd_val;
          end else if (found) begin
            if (op_q == scme_pkg::OP_SET)
              slot_val_mem[{col_q[CW-1:0], found_k}] <= val_q;
            else
              slot_val_mem[{col_q[CW-1:0], found_k}] <=
                scme_pkg::sat34(34'(rd_val) + 34'(val_q));
          end else if (fill_q >= FW'(SLOTS_PER_COL)) begin
            status <= scme_pkg::ST_FULL;
          end else begin
            slot_row_mem[{col_q[CW-1:0], fill_q[KW-1:0]}] <= row_q;
            slot_val_mem[{col_q[CW-1:0], fill_q[KW-1:0]}] <= val_q;
            fill_mem[col_q[CW-1:0]] <= fill_q + 1'b1;
            count <= count + 1'b1;
          end
        end
        S_MUL: begin
          // walk slots of the current column
          if (k >= (KW+1)'(fill_q)) begin
            if (op_q == scme_pkg::OP_SCALE && ci != (CW+1)'(scme_pkg::MaxCols - 1)) begin
              ci <= ci + 1'b1;
              col_q <= 6'(ci + 1'b1);
              fill_q <= fill_mem[(ci[CW-1:0] + 1'b1)];
              k <= '0;
            end else begin
              state <= S_OUT; out_valid <= 1'b1;
            end
          end else begin
            rd_row <= slot_row_mem[slot_addr];
            rd_val <= slot_val_mem[slot_addr];
            wait_cnt <= '0;
            state <= S_MULW;
          end
        end
        S_MULW: begin
          // wait while the multiplier's partial product and sum registers fill
          acc_row <= rd_row;
          wait_cnt <= wait_cnt + 1'b1;
          if (wait_cnt == 3'd1) state <= S_ACC;
          if (op_q == scme_pkg::OP_MUL) acc_rd <= acc_mem[rd_row[RW-1:0]];
        end
        S_ACC: begin
          if (op_q == scme_pkg::OP_SCALE)
            slot_val_mem[{col_q[CW-1:0], k[KW-1:0]}] <= scme_pkg::satq(prod);
          else if ({1'b0, acc_row} < 7'(scme_pkg::MaxRows))
            acc_mem[acc_row[RW-1:0]] <= scme_pkg::sat_acc(acc_rd, prod);
          state <= S_RES;
        end
        S_RES: begin
          k <= k + 1'b1;
          state <= S_MUL;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT)) else $error("out_valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (count == $past(count) || count == $past(count) + 10'd1))
    else $error("count jumped");
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 2'd3)) else $error("bad status");
`endif
endmodule

// ----- dv/scme_result_checker.sv -----
// result checker: watches the channels, predicts each result and compares it
module scme_result_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         op,
  input  logic [5:0]         row,
  input  logic [5:0]         col,
  input  logic signed [31:0] value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] data,
  input  logic [1:0]         status,
  input  logic [9:0]         nonzeros,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  output int                 fails,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Rows  = 64;
  localparam int Cols  = 64;
  localparam int Slots = 8;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic [9:0]         nonzeros;
  } matrix_result_t;

  matrix_result_t     expected_results[$];
  logic [6:0]         rows_cfg;
  logic [6:0]         cols_cfg;
  logic [5:0]         entry_row[Cols][Slots];
  logic signed [31:0] entry_val[Cols][Slots];
  int                 col_fill[Cols];
  logic signed [31:0] row_acc[Rows];
  int                 entry_count;

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return scme_pkg::SatMax;
    if (x < -64'sd2147483648) return scme_pkg::SatMin;
    return x[31:0];
  endfunction

  // q16.16 product, low fraction bits dropped toward minus infinity
  function automatic longint fix_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  function automatic matrix_result_t apply_op(logic [2:0] o, logic [5:0] r, logic [5:0] c,
                                              logic signed [31:0] v);
    matrix_result_t res;
    int nr;
    int nc;
    int hit;
    bit row_ok;
    bit col_ok;
    nr = (rows_cfg > Rows) ? Rows : rows_cfg;
    nc = (cols_cfg > Cols) ? Cols : cols_cfg;
    row_ok = r < nr;
    col_ok = c < nc;
    res.data = '0;
    res.status = scme_pkg::ST_OK;
    case (o)
      scme_pkg::OP_SET, scme_pkg::OP_ADD, scme_pkg::OP_READ: begin
        if (!row_ok || !col_ok) begin
          res.status = scme_pkg::ST_RANGE;
        end else begin
          hit = -1;
          for (int k = 0; k < col_fill[c]; k++)
            if (hit < 0 && entry_row[c][k] == r) hit = k;
          if (o == scme_pkg::OP_READ) begin
            if (hit >= 0) res.data = entry_val[c][hit];
          end else if (hit < 0 && col_fill[c] >= Slots) begin
            res.status = scme_pkg::ST_FULL;
          end else begin
            if (hit < 0) begin
              hit = col_fill[c];
              entry_row[c][hit] = r;
              entry_val[c][hit] = '0;
              col_fill[c]++;
              entry_count++;
            end
            if (o == scme_pkg::OP_SET) entry_val[c][hit] = v;
            else entry_val[c][hit] = clamp32(longint'(entry_val[c][hit]) + longint'(v));
          end
        end
      end
      scme_pkg::OP_MUL: begin
        if (!col_ok) res.status = scme_pkg::ST_RANGE;
        else
          // rows beyond rows_in_use still accumulate
          for (int k = 0; k < col_fill[c]; k++)
            row_acc[entry_row[c][k]] =
              clamp32(longint'(row_acc[entry_row[c][k]]) + fix_mul(entry_val[c][k], v));
      end
      scme_pkg::OP_RDCLR: begin
        if (!row_ok) begin
          res.status = scme_pkg::ST_RANGE;
        end else begin
          res.data = row_acc[r];
          row_acc[r] = '0;
        end
      end
      scme_pkg::OP_SCALE: begin
        for (int i = 0; i < Cols; i++)
          for (int k = 0; k < col_fill[i]; k++)
            entry_val[i][k] = clamp32(fix_mul(entry_val[i][k], v));
      end
      default: ;
    endcase
    res.nonzeros = entry_count[9:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    matrix_result_t want;
    matrix_result_t predicted;
    if (rst) begin
      rows_cfg = 7'd64;
      cols_cfg = 7'd64;
      for (int i = 0; i < Cols; i++) col_fill[i] = 0;
      for (int i = 0; i < Rows; i++) row_acc[i] = '0;
      entry_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == scme_pkg::REG_ROWS) rows_cfg = cfg_data;
        else rows_cfg = rows_cfg;
        if (cfg_index == scme_pkg::REG_COLS) cols_cfg = cfg_data;
      end
      if (in_valid && in_ready) begin
        predicted = apply_op(op, row, col, value);
        expected_results = {expected_results, predicted};
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (data !== want.data) report_mismatch("data", data, want.data);
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (nonzeros !== want.nonzeros) report_mismatch("nonzeros", nonzeros, want.nonzeros);
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ----- dv/sparse_column_matrix_engine_unit_test.sv -----
// testbench top: stimulus, idling phases and verdict for the matrix engine
module sparse_column_matrix_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int StallLimit = 30000;
  localparam int PhaseItems = 144;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         op = '0;
  logic [5:0]         row = '0;
  logic [5:0]         col = '0;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] data;
  logic [1:0]         status;
  logic [9:0]         nonzeros;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = scme_pkg::REG_ROWS;
  logic [6:0]         cfg_data = '0;

  int fails;
  int pending;
  int gap_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  int ops_sent = 0;
  int settings_used = 0;
  int rows_now = 64;
  int cols_now = 64;

  sparse_column_matrix_engine_unit u_top (.*);

  scme_result_checker u_checker (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_op(logic [2:0] o, logic [5:0] r, logic [5:0] c, logic signed [31:0] v);
    in_valid <= 1'b1;
    op <= o;
    row <= r;
    col <= c;
    value <= v;
    do @(posedge clk); while (!in_ready);
    ops_sent++;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sizes(logic [6:0] nr, logic [6:0] nc);
    wait_drained();
    write_reg(scme_pkg::REG_ROWS, nr);
    write_reg(scme_pkg::REG_COLS, nc);
    rows_now = (nr > 64) ? 64 : nr;
    cols_now = (nc > 64) ? 64 : nc;
    settings_used++;
  endtask

  function automatic logic [5:0] pick_index(int lim);
    int r;
    r = $urandom_range(99);
    // small indexes keep columns filling and entries being found again
    if (r < 75 && lim > 0) return 6'($urandom_range((lim > 10) ? 9 : lim - 1));
    if (r < 90 && lim > 0) return 6'($urandom_range(lim - 1));
    return 6'($urandom_range(63));
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $signed($urandom_range(262143)) - 32'sd131072;
    if (r < 85) return $urandom();
    if (r < 92) return scme_pkg::SatMax;
    if (r < 98) return scme_pkg::SatMin;
    return '0;
  endfunction

  task automatic random_op();
    int r;
    logic [2:0] o;
    r = $urandom_range(999);
    if (r < 250) o = scme_pkg::OP_SET;
    else if (r < 500) o = scme_pkg::OP_ADD;
    else if (r < 700) o = scme_pkg::OP_READ;
    else if (r < 840) o = scme_pkg::OP_MUL;
    else if (r < 970) o = scme_pkg::OP_RDCLR;
    else if (r < 978) o = scme_pkg::OP_SCALE;
    else if (r < 989) o = OP_SPARE_A;
    else o = OP_SPARE_B;
    if (o == scme_pkg::OP_SCALE)
      // half of the factors are mild so entries survive repeated scaling
      send_op(o, pick_index(rows_now), pick_index(cols_now),
              ($urandom_range(1)) ? $signed($urandom_range(131072)) : pick_value());
    else
      send_op(o, pick_index(rows_now), pick_index(cols_now), pick_value());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every op, full column, missing entry, unused ops
    send_op(scme_pkg::OP_READ, 6'd0, 6'd0, '0);
    send_op(scme_pkg::OP_SET, 6'd63, 6'd63, scme_pkg::SatMax);
    send_op(scme_pkg::OP_ADD, 6'd63, 6'd63, scme_pkg::SatMax);
    send_op(scme_pkg::OP_ADD, 6'd0, 6'd63, scme_pkg::SatMin);
    send_op(scme_pkg::OP_ADD, 6'd0, 6'd63, scme_pkg::SatMin);
    send_op(scme_pkg::OP_READ, 6'd63, 6'd63, '0);
    for (int i = 0; i < 9; i++)
      send_op(scme_pkg::OP_SET, 6'(i * 7), 6'd5, 32'sh00010000 + i);
    send_op(scme_pkg::OP_MUL, 6'd0, 6'd5, 32'sh00020000);
    send_op(scme_pkg::OP_MUL, 6'd0, 6'd63, 32'shffff8000);
    send_op(scme_pkg::OP_RDCLR, 6'd63, 6'd0, '0);
    send_op(scme_pkg::OP_RDCLR, 6'd14, 6'd0, '0);
    send_op(scme_pkg::OP_SCALE, 6'd0, 6'd0, 32'shfffe8000);
    send_op(scme_pkg::OP_READ, 6'd7, 6'd5, '0);
    send_op(OP_SPARE_A, 6'd63, 6'd63, scme_pkg::SatMax);
    send_op(OP_SPARE_B, 6'd0, 6'd0, scme_pkg::SatMin);

    // stale rows and columns above the sizes in use, then a zero size
    set_sizes(7'd10, 7'd4);
    send_op(scme_pkg::OP_MUL, 6'd0, 6'd5, 32'sh00010000);
    send_op(scme_pkg::OP_MUL, 6'd0, 6'd3, 32'sh00010000);
    send_op(scme_pkg::OP_RDCLR, 6'd49, 6'd0, '0);
    send_op(scme_pkg::OP_SCALE, 6'd0, 6'd0, 32'sh00008000);
    set_sizes(7'd0, 7'd0);
    send_op(scme_pkg::OP_SET, 6'd0, 6'd0, 32'sh00010000);
    send_op(scme_pkg::OP_RDCLR, 6'd0, 6'd0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_sizes(7'd64, 7'd64);
        1: set_sizes(7'd1, 7'd1);
        2: set_sizes(7'd127, 7'd100);
        3: set_sizes(7'd12, 7'd6);
        4: set_sizes(7'd65, 7'd2);
        default: set_sizes(7'($urandom_range(127)), 7'($urandom_range(127)));
      endcase
      gap_pct = (ph % 4 == 1 || ph % 4 == 3) ? 83 : 0;
      stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? 83 : 0;
      if (ph % 4 == 3) begin
        gap_pct = 16;
        stall_pct = 16;
      end
      for (int i = 0; i < PhaseItems; i++) random_op();
    end

    wait_drained();
    $display("covered %0d operations over %0d size settings", ops_sent, settings_used);
    $display("with gap and stall mixes of none, 83 and 16 percent");
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
